>>> hw/rtl/assert_macros.svh
// assertion macros used by config_crc_sync_tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while reset is active
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent, off while reset is active
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/cfgcrc_pkg.sv
// types, constants and command codes for the config crc sync tracker
package cfgcrc_pkg;

	// frame length that is adopted
	localparam int WIRE_SIZE = 128;
	// byte counter saturates one above the frame length
	localparam int COUNT_SAT = WIRE_SIZE + 1;
	localparam int COUNT_W = $clog2(COUNT_SAT + 1);

	typedef logic [COUNT_W-1:0] count_t;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] PERIOD_RESET = 32'd1000;

	// command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  data_byte;
		logic        last;
		logic [31:0] host_sum;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic        changed;
		logic        request;
		logic [31:0] held_checksum;
	} result_t;

endpackage

>>> hw/rtl/cfgcrc_crc_byte.sv
// byte-wide reflected crc-32 update, eight bit steps unrolled
module cfgcrc_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data_byte,
	output logic [31:0] crc_out
);

	// shift out one bit per step, folding in the polynomial on a set lsb
	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data_byte};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ cfgcrc_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

>>> hw/rtl/config_crc_sync_tracker.sv
// top level of the config crc sync tracker: crc over frames, host resync decisions
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------------------
//  item     | in        | item_valid / item_stall     | cmd data_byte last host_sum now_ms
//  result   | out       | result_valid / result_stall | accepted changed request held
//  cfg      | in        | cfg_we                      | cfg_wdata (request period, ms)
//
// one item per cycle while item_stall is low; state updates at the item transfer, and a
// query or a frame's last byte registers a result into the output register, or into the
// skid register when the output still holds an undelivered result; this two-entry output
// keeps items flowing while a result waits; item_stall rises only when both entries hold undelivered results.
// reset clears all state: crc all ones, counter, held crc and request time zero,
// request period 1000 ms, both output entries empty.
`include "assert_macros.svh"

module config_crc_sync_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  cfgcrc_pkg::item_t    item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output cfgcrc_pkg::result_t  result,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata
);

	logic [31:0]         period_q;
	logic [31:0]         crc_q;
	cfgcrc_pkg::count_t  cnt_q;
	logic [31:0]         held_q;
	logic [31:0]         last_req_q;
	logic                ever_q;

	logic [31:0]         crc_d;
	cfgcrc_pkg::count_t  cnt_d;
	logic [31:0]         held_d;
	logic [31:0]         last_req_d;
	logic                ever_d;

	logic [31:0]   crc_next;
	logic [31:0]   elapsed;
	logic          take;
	logic          push;
	logic          frame_end;
	cfgcrc_pkg::result_t res;

	logic                result_valid_q;
	cfgcrc_pkg::result_t result_q;
	logic                skid_valid_q;
	cfgcrc_pkg::result_t skid_q;
	logic                pop;

	cfgcrc_crc_byte u_crc (
		.crc_in    (crc_q),
		.data_byte (item.data_byte),
		.crc_out   (crc_next)
	);

	assign item_stall = skid_valid_q;
	assign take = item_valid && !item_stall;
	assign elapsed = item.now_ms - last_req_q;
	assign frame_end = take && item.cmd == cfgcrc_pkg::CMD_BYTE && item.last;

	// per-item state update and result
	always_comb begin
		crc_d = crc_q;
		cnt_d = cnt_q;
		held_d = held_q;
		last_req_d = last_req_q;
		ever_d = ever_q;
		push = 1'b0;
		res = '0;
		if (take) begin
			case (item.cmd)
				cfgcrc_pkg::CMD_BYTE: begin
					crc_d = crc_next;
					if (cnt_q < cfgcrc_pkg::count_t'(cfgcrc_pkg::COUNT_SAT)) begin
						cnt_d = cnt_q + cfgcrc_pkg::count_t'(1);
					end
					if (item.last) begin
						push = 1'b1;
						if (cnt_d == cfgcrc_pkg::count_t'(cfgcrc_pkg::WIRE_SIZE)) begin
							res.accepted = 1'b1;
							res.changed = (~crc_next != held_q);
							held_d = ~crc_next;
							ever_d = 1'b0;
						end
						crc_d = cfgcrc_pkg::CRC_INIT;
						cnt_d = '0;
					end
				end
				cfgcrc_pkg::CMD_QUERY: begin
					push = 1'b1;
					if (item.host_sum != held_q && (!ever_q || elapsed >= period_q)) begin
						res.request = 1'b1;
						last_req_d = item.now_ms;
						ever_d = 1'b1;
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
		res.held_checksum = held_d;
	end

	// tracker state and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= cfgcrc_pkg::PERIOD_RESET;
			crc_q <= cfgcrc_pkg::CRC_INIT;
			cnt_q <= '0;
			held_q <= '0;
			last_req_q <= '0;
			ever_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			crc_q <= crc_d;
			cnt_q <= cnt_d;
			held_q <= held_d;
			last_req_q <= last_req_d;
			ever_q <= ever_d;
		end
	end

	// output register with skid entry
	assign pop = result_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (result_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					result_valid_q <= 1'b1;
				end
			end else if (pop) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload of the output entries
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				result_q <= skid_q;
			end
		end else if (push) begin
			if (result_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				result_q <= res;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// checks
	`ASSERT_CLK(a_skid_behind_out, skid_valid_q |-> result_valid_q, "skid full, output empty")
	`ASSERT_CLK(a_count_bound, cnt_q <= cfgcrc_pkg::count_t'(cfgcrc_pkg::COUNT_SAT), "count high")
	`ASSERT_CLK(a_changed_accept, result_valid && result.changed |-> result.accepted, "bad changed")
	`ASSERT_CLK(a_request_alone, result_valid && result.request |-> !result.accepted, "bad request")
	`ASSERT_NEXT(a_frame_restart, frame_end, cnt_q == '0 && crc_q == cfgcrc_pkg::CRC_INIT, "no restart")

endmodule
